// ----- hw/rtl/psi_pkg.sv -----
// Package: shared word types, item codes and a helper function for the system interface.
`default_nettype none
package psi_pkg;

  // Item kinds carried in the mode field of an input word.
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_PIN   = 2'd2,
    MODE_TICK  = 2'd3
  } psi_mode_t;

  // Read chunk selects.
  typedef enum logic [1:0] {
    CHUNK_LOW  = 2'd0,
    CHUNK_HIGH = 2'd1,
    CHUNK_PLO  = 2'd2,
    CHUNK_PHI  = 2'd3
  } psi_chunk_t;

  localparam int unsigned LINES      = 16;
  localparam int unsigned TIMER_W    = 14;
  localparam logic [4:0]  ADDR_CLKSEL = 5'd0;
  localparam logic [4:0]  ADDR_LAST_INTERVAL = 5'd14;
  localparam logic [4:0]  ADDR_SOFT   = 5'd15;
  localparam logic [3:0]  TIMER_LINE  = 4'd3;
  localparam logic [3:0]  FIRST_MIRROR_PIN = 4'd7;
  localparam logic [4:0]  MIRROR_BASE = 5'd22;
  localparam logic [3:0]  LEVEL_NONE  = 4'hF;
  localparam logic        CFG_REG_MASK = 1'b0;

  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] address;
    logic       bit_value;
    logic [7:0] ext_pins;
  } psi_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       intreq;
    logic [3:0] int_level;
    logic       pin_strobe;
    logic [3:0] pin_index;
    logic       pin_level;
  } psi_out_t;

  // Lowest set line number; LEVEL_NONE when nothing is set.
  function automatic logic [3:0] lowest_line(input logic [LINES-1:0] act);
    logic [3:0] lvl;
    lvl = LEVEL_NONE;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (act[i]) begin
        lvl = 4'(i);
      end
    end
    return lvl;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/psi_apb.sv -----
// Configuration register block: the supported interrupt line mask behind an APB-style port.
`default_nettype none
module psi_apb (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [15:0]      int_mask
);
  import psi_pkg::*;

  logic [15:0] int_mask_r;
  logic [15:0] int_mask_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == CFG_REG_MASK);

  always_comb begin
    int_mask_nxt = int_mask_r;
    if (wr_en) begin
      int_mask_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_mask_r <= '0;
    end else begin
      int_mask_r <= int_mask_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == CFG_REG_MASK) begin
      prdata = {16'h0000, int_mask_r};
    end
  end

  assign int_mask = int_mask_r;
endmodule
`default_nettype wire

// ----- hw/rtl/psi_core.sv -----
// Interrupt, timer and pin state with the single-pass next-state and result logic.
`default_nettype none
module psi_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             take,
  input  wire psi_pkg::psi_in_t item,
  input  wire logic [15:0]      int_mask,
  output psi_pkg::psi_out_t     result
);
  import psi_pkg::*;

  logic [15:0]        line_r, line_nxt;
  logic               pend_r, pend_nxt;
  logic [15:0]        en_r, en_nxt;
  logic               act_r, act_nxt;
  logic [15:0]        pdir_r, pdir_nxt;
  logic [15:0]        pout_r, pout_nxt;
  logic [15:0]        mdir_r, mdir_nxt;
  logic [15:0]        mout_r, mout_nxt;
  logic [TIMER_W-1:0] ivl_r, ivl_nxt;
  logic [TIMER_W-1:0] dec_r, dec_nxt;
  logic [TIMER_W-1:0] lat_r, lat_nxt;
  logic               clk_mode_r, clk_mode_nxt;

  logic [7:0]  rd;
  logic [15:0] inact;
  logic [15:0] lines_act;
  logic [3:0]  pin;
  logic [3:0]  mir;
  logic [3:0]  ivl_idx;

  assign pin     = item.address[3:0];
  assign mir     = 4'(MIRROR_BASE - {1'b0, pin});
  assign ivl_idx = item.address[3:0] - 4'd1;
  assign inact   = ~line_r & int_mask;

  always_comb begin
    line_nxt     = line_r;
    pend_nxt     = pend_r;
    en_nxt       = en_r;
    pdir_nxt     = pdir_r;
    pout_nxt     = pout_r;
    mdir_nxt     = mdir_r;
    mout_nxt     = mout_r;
    ivl_nxt      = ivl_r;
    dec_nxt      = dec_r;
    lat_nxt      = lat_r;
    clk_mode_nxt = clk_mode_r;
    rd           = '0;
    result       = '0;

    unique case (psi_mode_t'(item.mode))
      MODE_READ: begin
        unique case (psi_chunk_t'(item.address[1:0]))
          CHUNK_LOW: begin
            if (clk_mode_r) begin
              rd = {lat_r[6:0], 1'b1};
            end else begin
              rd = ((inact[7:0] | item.ext_pins) & ~mdir_r[7:0]) | (mout_r[7:0] & mdir_r[7:0]);
            end
          end
          CHUNK_HIGH: begin
            if (clk_mode_r) begin
              rd = {~act_r, lat_r[13:7]};
            end else begin
              rd = ((inact[15:8] | item.ext_pins) & ~mdir_r[15:8])
                   | (mout_r[15:8] & mdir_r[15:8]);
            end
          end
          CHUNK_PLO: begin
            clk_mode_nxt = 1'b0;
            rd = (item.ext_pins & ~pdir_r[7:0]) | (pout_r[7:0] & pdir_r[7:0]);
          end
          CHUNK_PHI: begin
            clk_mode_nxt = 1'b0;
            rd = (item.ext_pins & ~pdir_r[15:8]) | (pout_r[15:8] & pdir_r[15:8]);
          end
        endcase
      end
      MODE_WRITE: begin
        priority if (item.address == ADDR_CLKSEL) begin
          if (clk_mode_r != item.bit_value) begin
            clk_mode_nxt = item.bit_value;
            if (item.bit_value) begin
              lat_nxt = (ivl_r != '0) ? dec_r : '0;
            end
          end
        end else if (item.address <= ADDR_LAST_INTERVAL) begin
          if (clk_mode_r) begin
            ivl_nxt[ivl_idx] = item.bit_value;
            dec_nxt          = ivl_nxt;
          end else begin
            en_nxt[pin] = item.bit_value;
            if (pin == TIMER_LINE) begin
              pend_nxt = 1'b0;
            end
          end
        end else if (item.address == ADDR_SOFT) begin
          if (clk_mode_r) begin
            if (!item.bit_value) begin
              pdir_nxt = '0;
              mdir_nxt = '0;
              en_nxt   = '0;
            end
          end else begin
            en_nxt[15] = item.bit_value;
          end
        end else begin
          // Pin output write; upper pins also drive their mirrored interrupt line.
          clk_mode_nxt   = 1'b0;
          pdir_nxt[pin]  = 1'b1;
          pout_nxt[pin]  = item.bit_value;
          if (pin >= FIRST_MIRROR_PIN) begin
            mdir_nxt[mir] = 1'b1;
            mout_nxt[mir] = item.bit_value;
          end
          result.pin_strobe = 1'b1;
          result.pin_index  = pin;
          result.pin_level  = item.bit_value;
        end
      end
      MODE_PIN: begin
        if (!item.address[4]) begin
          line_nxt[pin] = item.bit_value;
        end
      end
      MODE_TICK: begin
        if (ivl_r != '0) begin
          if (dec_r <= TIMER_W'(1)) begin
            pend_nxt = 1'b1;
            dec_nxt  = ivl_r;
          end else begin
            dec_nxt = dec_r - TIMER_W'(1);
          end
        end
      end
    endcase

    lines_act = line_nxt;
    if (ivl_nxt != '0) begin
      lines_act[TIMER_LINE] = pend_nxt;
    end
    lines_act = lines_act & en_nxt & ~mdir_nxt;
    act_nxt   = |lines_act;

    result.read_data = rd;
    result.intreq    = act_nxt;
    result.int_level = lowest_line(lines_act);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r     <= '0;
      pend_r     <= 1'b0;
      en_r       <= '0;
      act_r      <= 1'b0;
      pdir_r     <= '0;
      pout_r     <= '0;
      mdir_r     <= '0;
      mout_r     <= '0;
      ivl_r      <= '0;
      dec_r      <= '0;
      lat_r      <= '0;
      clk_mode_r <= 1'b0;
    end else if (take) begin
      line_r     <= line_nxt;
      pend_r     <= pend_nxt;
      en_r       <= en_nxt;
      act_r      <= act_nxt;
      pdir_r     <= pdir_nxt;
      pout_r     <= pout_nxt;
      mdir_r     <= mdir_nxt;
      mout_r     <= mout_nxt;
      ivl_r      <= ivl_nxt;
      dec_r      <= dec_nxt;
      lat_r      <= lat_nxt;
      clk_mode_r <= clk_mode_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/programmable_system_interface.sv -----
// Top level of the programmable system interface: input stage, core and result stage.
//
//   Channel  Direction  Handshake                 Word
//   in_      input      in_valid / in_stall       psi_in_t (mode, address, bit_value, ext_pins)
//   out_     output     out_valid / out_stall     psi_out_t (read_data .. pin_level)
//   cfg_     config     psel, penable, pready     supported interrupt mask at byte 0
//
// Each word is taken into the input register, passes through the core and is loaded into
// the result register, from which it can leave; one word is taken every cycle while the
// result side is not stalled. The whole update (the state bits, the decrementer step and
// the 16-line priority encoder) sits between those two registers in the core.
// Reset is synchronous and active low; it clears every state and valid register.
// A stall on a valid result holds the result register; an occupied input register then
// holds too and in_stall rises, so no word is lost or taken twice.
`default_nettype none
module programmable_system_interface (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire psi_pkg::psi_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output psi_pkg::psi_out_t      out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [2:0]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
  import psi_pkg::*;

  logic        in_valid_r, in_valid_nxt;
  psi_in_t     in_data_r;
  logic        out_valid_r, out_valid_nxt;
  psi_out_t    out_data_r;
  psi_out_t    core_result;
  logic        take;
  logic        out_hold;
  logic [15:0] int_mask;

  psi_apb u_apb (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .int_mask (int_mask)
  );

  // The result register is held while a finished word waits on a stalled receiver.
  assign out_hold = out_valid_r && out_stall;
  // The word in the input register moves on, and updates the state, when the
  // result register is free or being emptied in this cycle.
  assign take     = in_valid_r && !out_hold;
  assign in_stall = in_valid_r && out_hold;

  psi_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .item     (in_data_r),
    .int_mask (int_mask),
    .result   (core_result)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (!in_stall) begin
      in_valid_nxt = in_valid;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_data_r <= in_data;
    end
    if (take) begin
      out_data_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule
`default_nettype wire

// ----- hw/rtl/psi_checker.sv -----
// Port-level checker for the system interface and its bind to the top level.
`default_nettype none
module psi_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire psi_pkg::psi_out_t out_data
);
  import psi_pkg::*;

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid directly after reset");

  a_stall_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_stall_keeps_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result word changed while stalled");

  a_level_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.intreq |-> out_data.int_level == LEVEL_NONE)
    else $error("interrupt level not idle without a request");

  a_pin_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.pin_strobe |-> out_data.pin_index == 4'd0 && !out_data.pin_level)
    else $error("pin fields set without a pin strobe");
endmodule

bind programmable_system_interface psi_checker u_psi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
